// ----- design/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// UV sphere generator shared definitions
// Result kinds and the item record passed from the datapath to the emitter.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int unsigned IdxW = 20;
  localparam int unsigned PosW = 16;
  localparam int unsigned TexW = 16;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_REJECT   = 2'd2
  } kind_e;

  typedef struct packed {
    logic              reject;
    logic              is_edge;
    logic              upper;
    logic              lower;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [PosW-1:0]   pos_z;
    logic [TexW-1:0]   tex_u;
    logic [TexW-1:0]   tex_v;
    logic [IdxW-1:0]   k1;
    logic [IdxW-1:0]   k2;
  } item_t;

endpackage

// ----- design/uvs_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the top of the numerator must be
// below the divisor.
// ----------------------------------------------------------------------------
module uvs_div #(
  parameter int unsigned QW = 21,
  parameter int unsigned DW = 11,
  parameter int unsigned NW = QW + DW
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = num_i[NW-1:QW];
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign trial = {rem_in, low_in[QW-1-i]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      low_q[i] <= low_in;
      den_q[i] <= den_in;
      if (trial >= {1'b0, den_in}) begin
        rem_q[i] <= diff[DW-1:0];
        quo_q[i] <= {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_q[i] <= trial[DW-1:0];
        quo_q[i] <= {quo_in[QW-2:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- design/uvs_sine.sv -----
// ----------------------------------------------------------------------------
// Pipelined sine of a 20-bit turn angle
// Quadrant fold, then an odd polynomial by Horner steps, one multiply per
// stage; seven stages from angle to magnitude and sign.
// ----------------------------------------------------------------------------
module uvs_sine (
  input  logic        clk_i,
  input  logic [19:0] angle_i,
  output logic [30:0] mag_o,
  output logic        neg_o
);

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;
  localparam logic [30:0] Coef [4] = '{C7, C5, C3, C1};

  logic [30:0] t_q   [6];
  logic [1:0]  q_q   [6];
  logic [30:0] t2_q  [4];
  logic [30:0] acc_q [4];
  logic [30:0] mag_q;
  logic        neg_q;

  logic [18:0] r_fold;
  logic [61:0] sq;
  logic [61:0] fin;

  assign r_fold = angle_i[18] ? (19'h40000 - {1'b0, angle_i[17:0]}) : {1'b0, angle_i[17:0]};
  assign sq     = t_q[0] * t_q[0];
  assign fin    = t_q[5] * acc_q[3];

  always_ff @(posedge clk_i) begin
    t_q[0]  <= {r_fold, 12'd0};
    q_q[0]  <= angle_i[19:18];
    t2_q[0] <= sq[60:30];
    t_q[1]  <= t_q[0];
    q_q[1]  <= q_q[0];
    mag_q   <= fin[60:30];
    neg_q   <= q_q[5][1] && (fin[60:30] != 31'd0);
  end

  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic [30:0] acc_in;
    logic [61:0] prod;
    if (k == 0) begin : g_first
      assign acc_in = C9;
    end else begin : g_next
      assign acc_in = acc_q[k-1];
    end
    assign prod = t2_q[k] * acc_in;
    always_ff @(posedge clk_i) begin
      acc_q[k] <= Coef[k] - prod[60:30];
      t_q[k+2] <= t_q[k+1];
      q_q[k+2] <= q_q[k+1];
    end
    if (k < 3) begin : g_t2
      always_ff @(posedge clk_i) begin
        t2_q[k+1] <= t2_q[k];
      end
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ----- design/uvs_emit.sv -----
// ----------------------------------------------------------------------------
// Result emitter
// Turns one finished item into a vertex beat and up to two triangle beats, or a single reject beat.
// ----------------------------------------------------------------------------
module uvs_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  uvs_pkg::item_t       item_i,
  output logic                 res_valid_o,
  output logic [1:0]           kind_o,
  output logic [15:0]          pos_x_o,
  output logic [15:0]          pos_y_o,
  output logic [15:0]          pos_z_o,
  output logic [15:0]          tex_u_o,
  output logic [15:0]          tex_v_o,
  output logic [19:0]          corner_a_o,
  output logic [19:0]          corner_b_o,
  output logic [19:0]          corner_c_o,
  output logic                 last_o
);

  import uvs_pkg::*;

  logic            valid_q;
  kind_e           kind_q;
  logic [PosW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [TexW-1:0] tex_u_q, tex_v_q;
  logic [IdxW-1:0] ca_q, cb_q, cc_q;
  logic            last_q;
  logic            pend_up_q, pend_lo_q;
  logic [IdxW-1:0] k1_q, k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      kind_q    <= KIND_VERTEX;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pos_z_q   <= '0;
      tex_u_q   <= '0;
      tex_v_q   <= '0;
      ca_q      <= '0;
      cb_q      <= '0;
      cc_q      <= '0;
      last_q    <= 1'b0;
      pend_up_q <= 1'b0;
      pend_lo_q <= 1'b0;
      k1_q      <= '0;
      k2_q      <= '0;
    end else begin
      if (item_valid_i) begin
        valid_q <= 1'b1;
        ca_q    <= '0;
        cb_q    <= '0;
        cc_q    <= '0;
        k1_q    <= item_i.k1;
        k2_q    <= item_i.k2;
        if (item_i.reject) begin
          kind_q    <= KIND_REJECT;
          pos_x_q   <= '0;
          pos_y_q   <= '0;
          pos_z_q   <= '0;
          tex_u_q   <= '0;
          tex_v_q   <= '0;
          last_q    <= 1'b1;
          pend_up_q <= 1'b0;
          pend_lo_q <= 1'b0;
        end else begin
          kind_q    <= KIND_VERTEX;
          pos_x_q   <= item_i.pos_x;
          pos_y_q   <= item_i.pos_y;
          pos_z_q   <= item_i.pos_z;
          tex_u_q   <= item_i.tex_u;
          tex_v_q   <= item_i.tex_v;
          last_q    <= item_i.is_edge || (!item_i.upper && !item_i.lower);
          pend_up_q <= !item_i.is_edge && item_i.upper;
          pend_lo_q <= !item_i.is_edge && item_i.lower;
        end
      end else if (pend_up_q) begin
        valid_q   <= 1'b1;
        kind_q    <= KIND_TRIANGLE;
        pos_x_q   <= '0;
        pos_y_q   <= '0;
        pos_z_q   <= '0;
        tex_u_q   <= '0;
        tex_v_q   <= '0;
        ca_q      <= k1_q;
        cb_q      <= k2_q;
        cc_q      <= k1_q + 20'd1;
        last_q    <= !pend_lo_q;
        pend_up_q <= 1'b0;
      end else if (pend_lo_q) begin
        valid_q   <= 1'b1;
        kind_q    <= KIND_TRIANGLE;
        pos_x_q   <= '0;
        pos_y_q   <= '0;
        pos_z_q   <= '0;
        tex_u_q   <= '0;
        tex_v_q   <= '0;
        ca_q      <= k1_q + 20'd1;
        cb_q      <= k2_q;
        cc_q      <= k2_q + 20'd1;
        last_q    <= 1'b1;
        pend_lo_q <= 1'b0;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign tex_u_o     = tex_u_q;
  assign tex_v_o     = tex_v_q;
  assign corner_a_o  = ca_q;
  assign corner_b_o  = cb_q;
  assign corner_c_o  = cc_q;
  assign last_o      = last_q;

endmodule

// ----- design/uv_sphere_vertex_and_index_gen.sv -----
// ----------------------------------------------------------------------------
// UV sphere vertex and index generator
// The first result beat of an item follows the input registers, the dividers,
// the sines, the position products and rounding, and the emitter register;
// DivQ, the quotient bits of the pipelined dividers, depends on FRAC_BITS.
// A new item is refused while busy, leaving room for the up to three result beats per item on the one result port.
// Reset clears the control state and loads the register defaults 18 and 36.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_and_index_gen #(
  parameter int unsigned MAX_SEGMENTS = 1023,
  parameter int unsigned FRAC_BITS    = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  ring_i,
  input  logic [9:0]  sector_i,
  output logic        res_valid_o,
  output logic [1:0]  kind_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [15:0] pos_z_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o,
  output logic [19:0] corner_a_o,
  output logic [19:0] corner_b_o,
  output logic [19:0] corner_c_o,
  output logic        last_o
);

  import uvs_pkg::*;

  localparam int unsigned DivQ   = (FRAC_BITS + 1 > 21) ? FRAC_BITS + 1 : 21;
  localparam int unsigned DivD   = 11;
  localparam int unsigned DivN   = DivQ + DivD;
  localparam int unsigned TexDly = 9;
  localparam int unsigned SideD  = DivQ + TexDly;
  localparam logic [11:0] MaxSeg = 12'(MAX_SEGMENTS);
  localparam logic        RegStack = 1'b0;
  localparam logic        RegSlice = 1'b1;

  typedef struct packed {
    logic            vld;
    logic            reject;
    logic            is_edge;
    logic            upper;
    logic            lower;
    logic [IdxW-1:0] k1;
    logic [IdxW-1:0] k2;
    logic [10:0]     sl1;
  } side_t;

  function automatic logic [9:0] eff_count(logic [9:0] v);
    logic [9:0] r;
    if (v < 10'd3) begin
      r = 10'd3;
    end else if ({2'b00, v} > MaxSeg) begin
      r = MaxSeg[9:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_pos(logic [61:0] mag, logic neg, int unsigned sh);
    logic [62:0] m;
    logic [15:0] r;
    if (sh == 0) begin
      m = {1'b0, mag};
    end else begin
      m = ({1'b0, mag} + (63'd1 << (sh - 1))) >> sh;
    end
    if (neg) begin
      if (m > 63'd32768) begin
        r = 16'h8000;
      end else begin
        r = 16'd0 - m[15:0];
      end
    end else if (m > 63'd32767) begin
      r = 16'h7FFF;
    end else begin
      r = m[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] tex_sat(logic [DivQ-1:0] q);
    logic [15:0] r;
    if (q[DivQ-1:16] != '0) begin
      r = 16'hFFFF;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [9:0] stack_q, slice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q <= 10'd18;
      slice_q <= 10'd36;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegStack: stack_q <= pwdata[9:0];
        RegSlice: slice_q <= pwdata[9:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegStack: prdata = {22'd0, stack_q};
      RegSlice: prdata = {22'd0, slice_q};
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Input beat and pacing.
  logic       accept;
  logic [1:0] gap_q;
  logic       in_vld_q;
  logic [9:0] ring_q, sector_q, st_q, sl_q;

  assign accept = start && !busy;
  assign busy   = (gap_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= 2'd0;
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
      if (accept) begin
        gap_q <= 2'd2;
      end else if (gap_q != 2'd0) begin
        gap_q <= gap_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q   <= ring_i;
      sector_q <= sector_i;
      st_q     <= eff_count(stack_q);
      sl_q     <= eff_count(slice_q);
    end
  end

  // Dividers: angles and texture coordinates.
  logic [DivN-1:0] num_th, num_ph, num_tu, num_tv;
  logic [DivQ-1:0] quo_th, quo_ph, quo_tu, quo_tv;

  assign num_th = (DivN'(ring_q) << 20) + DivN'(st_q);
  assign num_ph = (DivN'(sector_q) << 20) + DivN'(sl_q[9:1]);
  assign num_tu = (DivN'(ring_q) << FRAC_BITS) + DivN'(st_q[9:1]);
  assign num_tv = (DivN'(sector_q) << FRAC_BITS) + DivN'(sl_q[9:1]);

  uvs_div #(.QW(DivQ), .DW(DivD)) u_div_th (
    .clk_i, .num_i(num_th), .den_i({st_q, 1'b0}), .quo_o(quo_th));
  uvs_div #(.QW(DivQ), .DW(DivD)) u_div_ph (
    .clk_i, .num_i(num_ph), .den_i({1'b0, sl_q}), .quo_o(quo_ph));
  uvs_div #(.QW(DivQ), .DW(DivD)) u_div_tu (
    .clk_i, .num_i(num_tu), .den_i({1'b0, st_q}), .quo_o(quo_tu));
  uvs_div #(.QW(DivQ), .DW(DivD)) u_div_tv (
    .clk_i, .num_i(num_tv), .den_i({1'b0, sl_q}), .quo_o(quo_tv));

  // Sines and cosines.
  logic [19:0] theta, phi;
  logic [30:0] st_m, ct_m, sp_m, cp_m;
  logic        st_n, ct_n, sp_n, cp_n;

  assign theta = quo_th[19:0];
  assign phi   = quo_ph[19:0];

  uvs_sine u_sin_th (.clk_i, .angle_i(theta),            .mag_o(st_m), .neg_o(st_n));
  uvs_sine u_cos_th (.clk_i, .angle_i(theta + 20'h40000), .mag_o(ct_m), .neg_o(ct_n));
  uvs_sine u_sin_ph (.clk_i, .angle_i(phi),              .mag_o(sp_m), .neg_o(sp_n));
  uvs_sine u_cos_ph (.clk_i, .angle_i(phi + 20'h40000),   .mag_o(cp_m), .neg_o(cp_n));

  // Texture coordinates wait for the position path.
  logic [15:0] tu_q [TexDly];
  logic [15:0] tv_q [TexDly];

  always_ff @(posedge clk_i) begin
    tu_q[0] <= tex_sat(quo_tu);
    tv_q[0] <= tex_sat(quo_tv);
    for (int i = 1; i < TexDly; i++) begin
      tu_q[i] <= tu_q[i-1];
      tv_q[i] <= tv_q[i-1];
    end
  end

  // Position products and rounding.
  logic [61:0] prod_x_q, prod_y_q;
  logic        neg_x_q, neg_y_q;
  logic [30:0] ctm_q;
  logic        ctn_q;
  logic [15:0] pos_x_q, pos_y_q, pos_z_q;

  always_ff @(posedge clk_i) begin
    prod_x_q <= st_m * cp_m;
    prod_y_q <= st_m * sp_m;
    neg_x_q  <= st_n ^ cp_n;
    neg_y_q  <= st_n ^ sp_n;
    ctm_q    <= ct_m;
    ctn_q    <= ct_n;
    pos_x_q  <= to_pos(prod_x_q, neg_x_q, 60 - FRAC_BITS);
    pos_y_q  <= to_pos(prod_y_q, neg_y_q, 60 - FRAC_BITS);
    pos_z_q  <= to_pos({31'd0, ctm_q}, ctn_q, 30 - FRAC_BITS);
  end

  // Item flags and vertex indices travel beside the datapath.
  side_t       side_q [SideD];
  side_t       side1_d;
  logic [20:0] k1_full;

  assign k1_full = 21'(ring_q) * 21'(sl_q) + 21'(ring_q) + 21'(sector_q);

  always_comb begin
    side1_d    = side_q[0];
    side1_d.k2 = side_q[0].k1 + {9'd0, side_q[0].sl1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SideD; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0].vld     <= in_vld_q;
      side_q[0].reject  <= (ring_q > st_q) || (sector_q > sl_q);
      side_q[0].is_edge <= (ring_q == st_q) || (sector_q == sl_q);
      side_q[0].upper   <= (ring_q != 10'd0);
      side_q[0].lower   <= (ring_q != st_q - 10'd1);
      side_q[0].k1      <= k1_full[19:0];
      side_q[0].k2      <= '0;
      side_q[0].sl1     <= {1'b0, sl_q} + 11'd1;
      side_q[1]         <= side1_d;
      for (int i = 2; i < SideD; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  item_t item;

  always_comb begin
    item.reject  = side_q[SideD-1].reject;
    item.is_edge = side_q[SideD-1].is_edge;
    item.upper   = side_q[SideD-1].upper;
    item.lower   = side_q[SideD-1].lower;
    item.pos_x   = pos_x_q;
    item.pos_y   = pos_y_q;
    item.pos_z   = pos_z_q;
    item.tex_u   = tu_q[TexDly-1];
    item.tex_v   = tv_q[TexDly-1];
    item.k1      = side_q[SideD-1].k1;
    item.k2      = side_q[SideD-1].k2;
  end

  uvs_emit u_emit (
    .clk_i,
    .rst_ni,
    .item_valid_i(side_q[SideD-1].vld),
    .item_i      (item),
    .res_valid_o,
    .kind_o,
    .pos_x_o,
    .pos_y_o,
    .pos_z_o,
    .tex_u_o,
    .tex_v_o,
    .corner_a_o,
    .corner_b_o,
    .corner_c_o,
    .last_o
  );

endmodule
